/* hw/rtl/hks_pkg.sv */
// Shared types, constants and reset value for the key-frame NAL splitter.
`default_nettype none

package hks_pkg;

    localparam int MAX_FRAME_BYTES = 1048576;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFS_W           = 20;
    localparam int LEN_W           = 21;
    localparam int MIN_FRAME_BYTES = 5;

    localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
    localparam logic [4:0] NAL_TYPE_NONE = 5'd0;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam int HAVE_SPS = 0;
    localparam int HAVE_PPS = 1;
    localparam int HAVE_IDR = 2;

    typedef enum logic [3:0] {
        PH_SEEK   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [1:0]       zero_run;
        t_phase           phase;
        logic [OFS_W-1:0] open_start;
        logic [4:0]       open_type;
        logic [OFS_W-1:0] sps_start;
        logic [LEN_W-1:0] sps_len;
        logic [OFS_W-1:0] pps_start;
        logic [LEN_W-1:0] pps_len;
        logic [OFS_W-1:0] idr_start;
        logic [2:0]       found;
        logic             ovf;
    } t_state;

    typedef struct packed {
        logic             split_valid;
        logic [OFS_W-1:0] sps_offset;
        logic [LEN_W-1:0] sps_length;
        logic [OFS_W-1:0] pps_offset;
        logic [LEN_W-1:0] pps_length;
        logic [OFS_W-1:0] idr_offset;
        logic [LEN_W-1:0] idr_length;
        logic             too_long;
    } t_result;

    function automatic t_state st_reset();
        t_state s;
        s            = '0;
        s.phase      = PH_SEEK;
        s.open_type  = NAL_TYPE_NONE;
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hks_step.sv */
// Per-byte next-state and frame result logic for the key-frame NAL splitter.
`default_nettype none

module hks_step
    import hks_pkg::*;
(
    input  wire t_state     i_st,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_state          o_st,
    output t_result         o_res
);

    always_comb begin
        t_state           s;
        t_result          r;
        logic             ovf_now;
        logic [OFS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] sps_len_f;
        logic [LEN_W-1:0] pps_len_f;

        s       = i_st;
        r       = '0;
        ovf_now = (i_st.pos >= POS_W'(MAX_FRAME_BYTES));
        start   = i_st.pos[OFS_W-1:0] - ((i_st.zero_run == 2'd3) ? OFS_W'(3) : OFS_W'(2));

        if (ovf_now) begin
            s.ovf = 1'b1;
        end else begin
            s.pos = i_st.pos + POS_W'(1);
            unique case (i_st.phase)
                PH_DONE: begin
                end
                PH_HEADER: begin
                    s.open_type = i_byte[4:0];
                    s.zero_run  = 2'd0;
                    s.phase     = PH_BODY;
                    if (i_byte[4:0] == NAL_TYPE_IDR) begin
                        s.idr_start       = i_st.open_start;
                        s.found[HAVE_IDR] = 1'b1;
                        s.phase           = PH_DONE;
                    end else if (i_byte[4:0] == NAL_TYPE_SPS) begin
                        s.sps_start       = i_st.open_start;
                        s.found[HAVE_SPS] = 1'b1;
                    end else if (i_byte[4:0] == NAL_TYPE_PPS) begin
                        s.pps_start       = i_st.open_start;
                        s.found[HAVE_PPS] = 1'b1;
                    end
                end
                PH_SEEK, PH_BODY: begin
                    if (i_byte == BYTE_ZERO) begin
                        if (i_st.zero_run != 2'd3) begin
                            s.zero_run = i_st.zero_run + 2'd1;
                        end
                    end else begin
                        s.zero_run = 2'd0;
                        if (i_byte == BYTE_ONE && i_st.zero_run >= 2'd2) begin
                            // close the open unit at the new start code
                            if (i_st.phase == PH_BODY) begin
                                if (i_st.open_type == NAL_TYPE_SPS) begin
                                    s.sps_len = LEN_W'(start) - LEN_W'(i_st.open_start);
                                end else if (i_st.open_type == NAL_TYPE_PPS) begin
                                    s.pps_len = LEN_W'(start) - LEN_W'(i_st.open_start);
                                end
                            end
                            s.open_start = start;
                            s.open_type  = NAL_TYPE_NONE;
                            s.phase      = PH_HEADER;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // frame end: close the open unit at the frame length
        len       = LEN_W'(i_st.pos) + LEN_W'(1);
        sps_len_f = s.sps_len;
        pps_len_f = s.pps_len;
        if (s.phase == PH_BODY) begin
            if (s.open_type == NAL_TYPE_SPS) begin
                sps_len_f = len - LEN_W'(s.open_start);
            end else if (s.open_type == NAL_TYPE_PPS) begin
                pps_len_f = len - LEN_W'(s.open_start);
            end
        end

        if (s.ovf) begin
            r.too_long = 1'b1;
        end else if (len >= LEN_W'(MIN_FRAME_BYTES)) begin
            r.split_valid = s.found[HAVE_SPS] && s.found[HAVE_PPS] && s.found[HAVE_IDR]
                            && (s.sps_start < s.pps_start) && (s.pps_start < s.idr_start);
            if (s.found[HAVE_SPS]) begin
                r.sps_offset = s.sps_start;
                r.sps_length = sps_len_f;
            end
            if (s.found[HAVE_PPS]) begin
                r.pps_offset = s.pps_start;
                r.pps_length = pps_len_f;
            end
            if (s.found[HAVE_IDR]) begin
                r.idr_offset = s.idr_start;
                r.idr_length = len - LEN_W'(s.idr_start);
            end
        end

        if (i_last) begin
            s = st_reset();
        end

        o_st  = s;
        o_res = r;
    end

endmodule

`default_nettype wire

/* hw/rtl/h264_keyframe_nal_splitter_unit.sv */
// Top level of the H.264 key-frame NAL splitter: request registers and parser state.
// A result passes from the input register through the parser step into the output register.
// Throughput: one byte per cycle while the input does not stall; the parser state register updates once per byte.
// The input stalls only while a finished result waits in the output register and the
// next byte in the input register is another frame end.
// Reset (synchronous, active low) empties both registers and returns to start-code search.
`default_nettype none

module h264_keyframe_nal_splitter_unit
    import hks_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_stream_byte,
    input  wire logic             i_frame_end,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_split_valid,
    output logic [OFS_W-1:0]      o_sps_offset,
    output logic [LEN_W-1:0]      o_sps_length,
    output logic [OFS_W-1:0]      o_pps_offset,
    output logic [LEN_W-1:0]      o_pps_length,
    output logic [OFS_W-1:0]      o_idr_offset,
    output logic [LEN_W-1:0]      o_idr_length,
    output logic                  o_too_long
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_state     r_st;
    t_state     n_st;
    t_result    n_res;
    t_result    r_res;
    logic       r_out_valid;

    logic out_free;
    logic proc;
    logic accept;

    hks_step u_step (
        .i_st   (r_st),
        .i_byte (r_in_byte),
        .i_last (r_in_end),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // a byte that ends no frame never waits on the output side
    assign proc       = r_in_valid && (!r_in_end || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_stream_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= st_reset();
        end else if (proc) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_end) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_split_valid = r_res.split_valid;
    assign o_sps_offset  = r_res.sps_offset;
    assign o_sps_length  = r_res.sps_length;
    assign o_pps_offset  = r_res.pps_offset;
    assign o_pps_length  = r_res.pps_length;
    assign o_idr_offset  = r_res.idr_offset;
    assign o_idr_length  = r_res.idr_length;
    assign o_too_long    = r_res.too_long;

endmodule

`default_nettype wire

/* dv/tb_h264_keyframe_nal_splitter_unit.sv */
// Testbench for the H.264 key-frame NAL splitter: byte stimulus, frame-level prediction, result checks.
module tb_h264_keyframe_nal_splitter_unit
    import hks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 4000000;
    localparam int unsigned RANDOM_BYTES  = 1250;
    localparam int unsigned RANDOM_FRAMES = 40;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned DRAIN_CYCLES  = 10;

    // Predicts the split of each access unit and holds the splits still owed by the block.
    class keyframe_scoreboard;
        t_result     pending_splits[$];
        int unsigned errors;
        int unsigned byte_pos;
        int unsigned zeros_seen;
        t_phase      phase;
        int unsigned open_at;
        logic [4:0]  open_kind;
        int unsigned sps_at;
        int unsigned sps_bytes;
        int unsigned pps_at;
        int unsigned pps_bytes;
        int unsigned idr_at;
        bit          got_sps;
        bit          got_pps;
        bit          got_idr;
        bit          overflowed;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos   = 0;
            zeros_seen = 0;
            phase      = PH_SEEK;
            open_at    = 0;
            open_kind  = NAL_TYPE_NONE;
            sps_at     = 0;
            sps_bytes  = 0;
            pps_at     = 0;
            pps_bytes  = 0;
            idr_at     = 0;
            got_sps    = 0;
            got_pps    = 0;
            got_idr    = 0;
            overflowed = 0;
        endfunction

        function void close_nal(int unsigned end_pos);
            if (open_kind == NAL_TYPE_SPS) begin
                sps_bytes = end_pos - open_at;
            end else if (open_kind == NAL_TYPE_PPS) begin
                pps_bytes = end_pos - open_at;
            end
        endfunction

        function void scan_byte(int unsigned p, logic [7:0] b);
            logic [4:0]  t;
            int unsigned code_start;
            if (phase == PH_DONE) begin
                return;
            end
            if (phase == PH_HEADER) begin
                t          = b[4:0];
                open_kind  = t;
                zeros_seen = 0;
                if (t == NAL_TYPE_IDR) begin
                    idr_at  = open_at;
                    got_idr = 1;
                    phase   = PH_DONE;
                    return;
                end
                if (t == NAL_TYPE_SPS) begin
                    sps_at  = open_at;
                    got_sps = 1;
                end else if (t == NAL_TYPE_PPS) begin
                    pps_at  = open_at;
                    got_pps = 1;
                end
                phase = PH_BODY;
                return;
            end
            if (b == BYTE_ZERO) begin
                if (zeros_seen < 3) begin
                    zeros_seen++;
                end
                return;
            end
            if (b == BYTE_ONE && zeros_seen >= 2) begin
                code_start = p - ((zeros_seen >= 3) ? 3 : 2);
                if (phase == PH_BODY) begin
                    close_nal(code_start);
                end
                open_at   = code_start;
                open_kind = NAL_TYPE_NONE;
                phase     = PH_HEADER;
            end
            zeros_seen = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_result     want;
            int unsigned p;
            int unsigned frame_len;
            p = byte_pos;
            if (p >= MAX_FRAME_BYTES) begin
                overflowed = 1;
            end else begin
                scan_byte(p, b);
                byte_pos = p + 1;
            end
            if (!last) begin
                return;
            end
            want      = '0;
            frame_len = p + 1;
            if (overflowed) begin
                want.too_long = 1'b1;
            end else if (frame_len >= MIN_FRAME_BYTES) begin
                if (phase == PH_BODY) begin
                    close_nal(frame_len);
                end
                want.split_valid = got_sps && got_pps && got_idr &&
                                   sps_at < pps_at && pps_at < idr_at;
                if (got_sps) begin
                    want.sps_offset = OFS_W'(sps_at);
                    want.sps_length = LEN_W'(sps_bytes);
                end
                if (got_pps) begin
                    want.pps_offset = OFS_W'(pps_at);
                    want.pps_length = LEN_W'(pps_bytes);
                end
                if (got_idr) begin
                    want.idr_offset = OFS_W'(idr_at);
                    want.idr_length = LEN_W'(frame_len - idr_at);
                end
            end
            pending_splits.push_back(want);
            clear_frame();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%s mismatch: expected %0d, actual %0d", name, want, got);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_splits.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("result with nothing pending: split_valid %0d too_long %0d",
                             got.split_valid, got.too_long);
                end
                return;
            end
            want = pending_splits.pop_front();
            check_field("split_valid", want.split_valid, got.split_valid);
            check_field("sps_offset", want.sps_offset, got.sps_offset);
            check_field("sps_length", want.sps_length, got.sps_length);
            check_field("pps_offset", want.pps_offset, got.pps_offset);
            check_field("pps_length", want.pps_length, got.pps_length);
            check_field("idr_offset", want.idr_offset, got.idr_offset);
            check_field("idr_length", want.idr_length, got.idr_length);
            check_field("too_long", want.too_long, got.too_long);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_stream_byte = 8'h00;
    logic             i_frame_end = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_split_valid;
    logic [OFS_W-1:0] o_sps_offset;
    logic [LEN_W-1:0] o_sps_length;
    logic [OFS_W-1:0] o_pps_offset;
    logic [LEN_W-1:0] o_pps_length;
    logic [OFS_W-1:0] o_idr_offset;
    logic [LEN_W-1:0] o_idr_length;
    logic             o_too_long;

    keyframe_scoreboard sb;
    t_result            observed;
    logic [7:0]         frame_q[$];
    int unsigned        cycles = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        frames_sent = 0;
    int unsigned        burst_left = 0;
    bit                 gaps_on = 1;
    int unsigned        stall_left = 0;
    int unsigned        stall_pct = 0;

    h264_keyframe_nal_splitter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .i_frame_end   (i_frame_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_split_valid (o_split_valid),
        .o_sps_offset  (o_sps_offset),
        .o_sps_length  (o_sps_length),
        .o_pps_offset  (o_pps_offset),
        .o_pps_length  (o_pps_length),
        .o_idr_offset  (o_idr_offset),
        .o_idr_length  (o_idr_length),
        .o_too_long    (o_too_long)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: segments of random length, each with its own stall density.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 75;
                default: stall_pct = 100;
            endcase
        end
        stall_left--;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Outputs only move at the rising edge, so the falling edge sees what the next edge accepts.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            observed.split_valid = o_split_valid;
            observed.sps_offset  = o_sps_offset;
            observed.sps_length  = o_sps_length;
            observed.pps_offset  = o_pps_offset;
            observed.pps_length  = o_pps_length;
            observed.idr_offset  = o_idr_offset;
            observed.idr_length  = o_idr_length;
            observed.too_long    = o_too_long;
            sb.check_result(observed);
        end
    end

    // Called just after a rising edge; returns just after the edge that takes the request.
    task automatic send_byte(logic [7:0] b, logic last);
        bit taken;
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        i_frame_end   <= last;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[k]) begin
            send_byte(frame_q[k], k == frame_q.size() - 1);
        end
        frames_sent++;
    endtask

    // Hold the sender until every owed split has come back.
    task automatic drain_splits();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_splits.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return BYTE_ZERO;
            3: return BYTE_ONE;
            4: return 8'h03;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_nal(logic [4:0] nal);
        int unsigned body_len;
        if ($urandom_range(0, 1) == 0) begin
            frame_q.push_back(BYTE_ZERO);
        end
        frame_q.push_back(BYTE_ZERO);
        frame_q.push_back(BYTE_ZERO);
        frame_q.push_back(BYTE_ONE);
        frame_q.push_back({3'($urandom), nal});
        body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
        repeat (body_len) frame_q.push_back(body_byte());
    endtask

    task automatic build_random_frame();
        int unsigned kind;
        int unsigned cut;
        frame_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 24)) frame_q.push_back(body_byte());
        end else if (kind == 1) begin
            repeat ($urandom_range(1, 4)) frame_q.push_back(body_byte());
        end else if (kind <= 7) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) frame_q.push_back(body_byte());
            end
            repeat ($urandom_range(0, 2)) push_nal(5'($urandom_range(9, 12)));
            push_nal(NAL_TYPE_SPS);
            if ($urandom_range(0, 3) == 0) begin
                push_nal(NAL_TYPE_SPS);
            end
            repeat ($urandom_range(0, 1)) push_nal(5'd6);
            push_nal(NAL_TYPE_PPS);
            push_nal(NAL_TYPE_IDR);
            repeat ($urandom_range(0, 2)) push_nal(5'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 4))
                    0: push_nal(NAL_TYPE_SPS);
                    1: push_nal(NAL_TYPE_PPS);
                    2: push_nal(NAL_TYPE_IDR);
                    default: push_nal(5'($urandom));
                endcase
            end
        end
        // Truncate now and then to get broken sequences.
        if ($urandom_range(0, 9) == 0 && frame_q.size() > 1) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) begin
                void'(frame_q.pop_back());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Four- and three-byte codes, SPS < PPS < IDR.
        frame_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01, 8'h68,
                    8'hCE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88};
        send_frame();
        // PPS ahead of SPS, header types with high bits set.
        frame_q = '{8'h00, 8'h00, 8'h01, 8'hE8, 8'h00, 8'h00, 8'h01, 8'hE7, 8'h00, 8'h00,
                    8'h01, 8'h25, 8'hFF};
        send_frame();
        // Back-to-back short frames.
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h00};
        send_frame();
        // Zero header before a four-byte run, SPS only, start code on the last byte.
        frame_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00,
                    8'h01};
        send_frame();
        drain_splits();

        bytes_sent = 0;
        frames_sent = 0;

        while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES) begin
            build_random_frame();
            send_frame();
            if ($urandom_range(0, 19) == 0) begin
                drain_splits();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_splits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_splits.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
